// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the ellipse rasterizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is held.
`define MER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a clock edge.
`define MER_ASSERT_NEVER(lbl, cond, msg) \
  `MER_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/core/mer_pkg.sv =====
// Shared widths, codes and types of the midpoint ellipse rasterizer.
package mer_pkg;

  localparam int COORD_BITS    = 10;
  localparam int RADIUS_BITS   = 9;
  localparam int OFF_BITS      = RADIUS_BITS + 1;
  localparam int DEC_BITS      = 4 * RADIUS_BITS + 8;
  localparam int OUT_BITS      = COORD_BITS + 2;
  localparam int SQ_BITS       = 2 * RADIUS_BITS;
  localparam int PROD_BITS     = SQ_BITS + OFF_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_RADIUS_X,
    CFG_RADIUS_Y
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REG_IDLE,
    REG_ONE,
    REG_TWO
  } region_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_PA,
    S_PB,
    S_PC,
    S_UPD
  } state_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius_x;
    logic [RADIUS_BITS-1:0] radius_y;
  } cfg_t;

  typedef struct packed {
    logic [SQ_BITS-1:0]  a;
    logic [OFF_BITS-1:0] b;
  } mul_op_t;

endpackage

// ===== rtl/core/mer_in_if.sv =====
// Step request channel: one item carries the restart flag.
interface mer_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// ===== rtl/core/mer_out_if.sv =====
// Point channel: one item carries the four mirrored coordinates and flags.
interface mer_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mer_pkg::OUT_BITS-1:0] right_x;
  logic signed [mer_pkg::OUT_BITS-1:0] left_x;
  logic signed [mer_pkg::OUT_BITS-1:0] lower_y;
  logic signed [mer_pkg::OUT_BITS-1:0] upper_y;
  logic                                 point_valid;
  logic                                 done_res;

  modport source (output valid, output right_x, output left_x, output lower_y,
                  output upper_y, output point_valid, output done_res, input ready);
  modport sink (input valid, input right_x, input left_x, input lower_y,
                input upper_y, input point_valid, input done_res, output ready);
endinterface

// ===== rtl/core/mer_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface mer_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mer_pkg::CFG_IDX_BITS-1:0]  index;
  logic [mer_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/mer_cfg.sv =====
// Configuration register file: center and radii.
module mer_cfg (
  input  logic          clk,
  input  logic          rst_n,
  mer_cfg_if.sink       cfg_ch,
  output mer_pkg::cfg_t cfg
);

  mer_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg            = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (mer_pkg::cfg_idx_t'(cfg_ch.index))
        mer_pkg::CFG_CENTER_X: cfg_r.center_x <= cfg_ch.data[mer_pkg::COORD_BITS-1:0];
        mer_pkg::CFG_CENTER_Y: cfg_r.center_y <= cfg_ch.data[mer_pkg::COORD_BITS-1:0];
        mer_pkg::CFG_RADIUS_X: cfg_r.radius_x <= cfg_ch.data[mer_pkg::RADIUS_BITS-1:0];
        mer_pkg::CFG_RADIUS_Y: cfg_r.radius_y <= cfg_ch.data[mer_pkg::RADIUS_BITS-1:0];
      endcase
    end
  end

endmodule

// ===== rtl/core/mer_mul.sv =====
// Shared multiplier with a registered product.
module mer_mul (
  input  logic                            clk,
  input  mer_pkg::mul_op_t                op,
  output logic [mer_pkg::PROD_BITS-1:0]  prod_r
);

  logic [mer_pkg::PROD_BITS-1:0] prod_nxt;

  assign prod_nxt = mer_pkg::PROD_BITS'(op.a) * mer_pkg::PROD_BITS'(op.b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== rtl/core/mer_seq.sv =====
// Step sequencer, decision update and point output register.
`include "assert_macros.svh"

module mer_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  mer_in_if.sink                         in_ch,
  mer_out_if.source                      out_ch,
  input  mer_pkg::cfg_t                  cfg,
  output mer_pkg::mul_op_t               mul_op,
  input  logic [mer_pkg::PROD_BITS-1:0] prod
);

  localparam int OB = mer_pkg::OFF_BITS;
  localparam int DB = mer_pkg::DEC_BITS;
  localparam int UB = mer_pkg::OUT_BITS;
  localparam int SB = mer_pkg::SQ_BITS;

  mer_pkg::state_t  state_r, state_nxt;
  mer_pkg::region_t region_r, region_nxt;
  logic             restart_r;
  logic [OB-1:0]    off_x_r, off_x_nxt;
  logic [OB-1:0]    off_y_r, off_y_nxt;
  logic [DB-1:0]    dec_r, dec_nxt;
  logic [SB-1:0]    rx2_r, ry2_r;
  logic [mer_pkg::PROD_BITS-1:0] pa_r, pb_r;

  logic                 out_valid_r;
  logic signed [UB-1:0] out_right_r, out_left_r, out_lower_r, out_upper_r;
  logic signed [UB-1:0] right_nxt, left_nxt, lower_nxt, upper_nxt;
  logic                 out_pv_r, out_done_r, pv_nxt, done_nxt;

  logic          upd_go;
  logic [DB-1:0] rx2_e, ry2_e, pa_e, pb_e, pc_e, step_e;
  logic          dec_le, slope_le;

  assign upd_go = (state_r == mer_pkg::S_UPD) && (!out_valid_r || out_ch.ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mer_pkg::S_IDLE: if (in_ch.valid) state_nxt = mer_pkg::S_SQX;
      mer_pkg::S_SQX:  state_nxt = mer_pkg::S_SQY;
      mer_pkg::S_SQY:  state_nxt = mer_pkg::S_PA;
      mer_pkg::S_PA:   state_nxt = mer_pkg::S_PB;
      mer_pkg::S_PB:   state_nxt = mer_pkg::S_PC;
      mer_pkg::S_PC:   state_nxt = mer_pkg::S_UPD;
      mer_pkg::S_UPD:  if (upd_go) state_nxt = mer_pkg::S_IDLE;
      default:         state_nxt = mer_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: input ready and multiplier operands
  always_comb begin
    in_ch.ready = (state_r == mer_pkg::S_IDLE);
    mul_op      = '0;
    unique case (state_r)
      mer_pkg::S_SQX: begin
        mul_op.a = SB'(cfg.radius_x);
        mul_op.b = OB'(cfg.radius_x);
      end
      mer_pkg::S_SQY: begin
        mul_op.a = SB'(cfg.radius_y);
        mul_op.b = OB'(cfg.radius_y);
      end
      mer_pkg::S_PA: begin
        mul_op.a = rx2_r;
        mul_op.b = restart_r ? OB'(cfg.radius_y) : off_y_r;
      end
      mer_pkg::S_PB: begin
        mul_op.a = ry2_r;
        mul_op.b = off_x_r;
      end
      // hold the region-2 start product while the update waits
      mer_pkg::S_PC, mer_pkg::S_UPD: begin
        mul_op.a = ry2_r;
        mul_op.b = OB'(cfg.radius_x);
      end
      default: mul_op = '0;
    endcase
  end

  // Decision and offset update; pa = rx2*y, pb = ry2*x, pc = ry2*rx
  always_comb begin
    rx2_e    = DB'(rx2_r);
    ry2_e    = DB'(ry2_r);
    pa_e     = DB'(pa_r);
    pb_e     = DB'(pb_r);
    pc_e     = DB'(prod);
    dec_le   = (dec_r == '0) || dec_r[DB-1];
    slope_le = (pb_r <= pa_r);
    step_e   = '0;

    off_x_nxt  = off_x_r;
    off_y_nxt  = off_y_r;
    dec_nxt    = dec_r;
    region_nxt = region_r;
    pv_nxt     = 1'b1;
    done_nxt   = 1'b0;

    if (restart_r) begin
      off_x_nxt  = '0;
      off_y_nxt  = OB'(cfg.radius_y);
      dec_nxt    = (ry2_e << 2) - (pa_e << 2) + rx2_e;
      region_nxt = mer_pkg::REG_ONE;
    end else begin
      unique case (region_r)
        mer_pkg::REG_ONE: begin
          if ((off_y_r != '0) && slope_le) begin
            off_x_nxt = off_x_r + OB'(1);
            // ry2 times the new x, zero where x wraps
            step_e = (off_x_r == '1) ? '0 : (pb_e + ry2_e);
            if (dec_le) begin
              dec_nxt = dec_r + (step_e << 3) + (ry2_e << 2);
            end else begin
              off_y_nxt = off_y_r - OB'(1);
              dec_nxt   = dec_r + (step_e << 3) - ((pa_e - rx2_e) << 3) + (ry2_e << 2);
            end
          end else begin
            off_x_nxt  = OB'(cfg.radius_x);
            off_y_nxt  = '0;
            dec_nxt    = (rx2_e << 2) - (pc_e << 2) + ry2_e;
            region_nxt = mer_pkg::REG_TWO;
          end
        end
        mer_pkg::REG_TWO: begin
          if ((off_x_r != '0) && !slope_le) begin
            off_y_nxt = off_y_r + OB'(1);
            // rx2 times the new y, zero where y wraps
            step_e = (off_y_r == '1) ? '0 : (pa_e + rx2_e);
            if (dec_le) begin
              dec_nxt = dec_r + (step_e << 3) + (rx2_e << 2);
            end else begin
              off_x_nxt = off_x_r - OB'(1);
              dec_nxt   = dec_r + (step_e << 3) - ((pb_e - ry2_e) << 3) + (rx2_e << 2);
            end
          end else begin
            region_nxt = mer_pkg::REG_IDLE;
            pv_nxt     = 1'b0;
            done_nxt   = 1'b1;
          end
        end
        default: begin
          region_nxt = mer_pkg::REG_IDLE;
          pv_nxt     = 1'b0;
          done_nxt   = 1'b1;
        end
      endcase
    end

    if (pv_nxt) begin
      right_nxt = $signed(UB'(cfg.center_x) + UB'(off_x_nxt));
      left_nxt  = $signed(UB'(cfg.center_x) - UB'(off_x_nxt));
      lower_nxt = $signed(UB'(cfg.center_y) + UB'(off_y_nxt));
      upper_nxt = $signed(UB'(cfg.center_y) - UB'(off_y_nxt));
    end else begin
      right_nxt = '0;
      left_nxt  = '0;
      lower_nxt = '0;
      upper_nxt = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mer_pkg::S_IDLE;
      region_r    <= mer_pkg::REG_IDLE;
      off_x_r     <= '0;
      off_y_r     <= '0;
      dec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_go) begin
        region_r    <= region_nxt;
        off_x_r     <= off_x_nxt;
        off_y_r     <= off_y_nxt;
        dec_r       <= dec_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operand captures and point payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) restart_r <= in_ch.restart;
    if (state_r == mer_pkg::S_SQY) rx2_r <= prod[SB-1:0];
    if (state_r == mer_pkg::S_PA)  ry2_r <= prod[SB-1:0];
    if (state_r == mer_pkg::S_PB)  pa_r  <= prod;
    if (state_r == mer_pkg::S_PC)  pb_r  <= prod;
    if (upd_go) begin
      out_right_r <= right_nxt;
      out_left_r  <= left_nxt;
      out_lower_r <= lower_nxt;
      out_upper_r <= upper_nxt;
      out_pv_r    <= pv_nxt;
      out_done_r  <= done_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.right_x     = out_right_r;
  assign out_ch.left_x      = out_left_r;
  assign out_ch.lower_y     = out_lower_r;
  assign out_ch.upper_y     = out_upper_r;
  assign out_ch.point_valid = out_pv_r;
  assign out_ch.done_res    = out_done_r;

  `MER_ASSERT_NEVER(a_pv_done_excl, out_valid_r && out_pv_r && out_done_r, "point and done both set")
  `MER_ASSERT(a_done_idle, (out_valid_r && out_done_r) |-> (region_r == mer_pkg::REG_IDLE), "done item while a region is active")
  `MER_ASSERT(a_empty_zero, (out_valid_r && !out_pv_r) |-> (out_right_r == '0 && out_left_r == '0 && out_lower_r == '0 && out_upper_r == '0), "empty item has nonzero coordinates")
  `MER_ASSERT(a_upd_order, (state_r == mer_pkg::S_UPD) |-> ($past(state_r) == mer_pkg::S_PC || $past(state_r) == mer_pkg::S_UPD), "update entered out of sequence")

endmodule

// ===== rtl/core/midpoint_ellipse_rasterizer.sv =====
// Midpoint ellipse rasterizer: top level with config, multiplier and sequencer.
// Each accepted step item yields one point item: the next boundary point of
// the ellipse set by the center and radius registers, mirrored into four
// screen coordinates, or an empty item with done set once both regions are
// through. A step item with restart set starts again at (0, radius_y). The
// block takes a new step item only after the previous one is updated: after
// the accepting cycle a single multiplier is stepped through five products
// (both radii squared, then the two slope products and the region-2 start
// product), followed by the decision update; ready returns once the update
// is done. The finished point sits in an output register, so the next step
// is taken while that point still waits downstream; the update of that next
// step holds until the register is free. Configuration writes are accepted
// every cycle and take effect once registered, also during a step.
module midpoint_ellipse_rasterizer (
  input logic       clk,
  input logic       rst_n,
  mer_in_if.sink    in_ch,
  mer_out_if.source out_ch,
  mer_cfg_if.sink   cfg_ch
);

  mer_pkg::cfg_t                 cfg;
  mer_pkg::mul_op_t              mul_op;
  logic [mer_pkg::PROD_BITS-1:0] prod;

  mer_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  mer_mul u_mul (
    .clk    (clk),
    .op     (mul_op),
    .prod_r (prod)
  );

  mer_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg),
    .mul_op (mul_op),
    .prod   (prod)
  );

endmodule
